>>> hw/rtl/dst_pkg.sv
// Package for the device status table: sizes, entry layout, outcome codes,
// controller state and command/status structs, byte-mask helpers.
// No dependencies; used by all device status table files.
package dst_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);

  // Field widths fixed by the interface
  localparam int SLOT_W = 5;
  localparam int OCC_OUT_W = 6;

  // One stored entry
  typedef struct packed {
    logic [63:0] ident;
    logic [7:0]  kind;
    logic [3:0]  length;
    logic [63:0] payload;
    logic [31:0] version;
  } entry_t;

  // Value of an entry that was never written
  localparam entry_t ENTRY_RESET = '{
    ident:   64'h0,
    kind:    8'h0,
    length:  4'h0,
    payload: 64'h0,
    version: 32'hFFFF_FFFF
  };

  localparam logic [31:0] STAMP_RESET = 32'hFFFF_FFFF;

  // Operation codes
  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_SYNC   = 1'b1;

  // Result outcome codes
  typedef enum logic [2:0] {
    OUT_UPDATED      = 3'd0,
    OUT_CREATED      = 3'd1,
    OUT_FULL         = 3'd2,
    OUT_SYNC_UNKNOWN = 3'd3,
    OUT_SYNC_APPLIED = 3'd4,
    OUT_LOCAL_NEWER  = 3'd5
  } outcome_e;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic start;   // capture the incoming transaction, clear search state
    logic scan;    // issue one table read and advance the scan pointer
    logic commit;  // write back the entry and load the result register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // current scan read is the last entry
    logic out_free;   // result register can take a new result this cycle
  } ctrl_sts_t;

  // Clamp a byte count to eight
  function automatic logic [3:0] clamp_count(input logic [3:0] n);
    clamp_count = (n > 4'd8) ? 4'd8 : n;
  endfunction

  // Mask of the n leading bytes (byte 0 in the low bits)
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < n) m[8*b +: 8] = 8'hFF;
    end
    byte_mask = m;
  endfunction

endpackage

>>> hw/rtl/device_status_table.sv
// Top level of the device status table: controller plus datapath.
// Depends on dst_pkg, dst_ctrl, dst_datapath.
//
//   channel   handshake               payload
//   -------   ---------------------   ------------------------------------------
//   in        in_valid_i/in_ready_o   operation, dev_id, node_kind, status_bytes,
//                                     status_count, sync_stamp
//   out       out_valid_o/out_ready_i outcome, slot, reply_*, occupied_count
//   cfg       cfg_we_i (no wait)      cfg_wdata_i -> new_node_stamp
//
// One transaction goes from accept through a scan state with one memory read
// per entry over the single read port, a drain state for the last registered
// read and a commit state that loads the result register and sets it valid.
// A new transaction can be accepted the cycle after the previous commit, so
// transactions never overlap; the result register holds while out_ready_i
// is low, and commit waits for it.
// Reset is asynchronous, active low; all entries read as empty right after
// reset through per-entry valid bits, no clearing pass.
module device_status_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [31:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [63:0]        dev_id_i,
  input  logic [7:0]         node_kind_i,
  input  logic [63:0]        status_bytes_i,
  input  logic [3:0]         status_count_i,
  input  logic signed [31:0] sync_stamp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         outcome_o,
  output logic [4:0]         slot_o,
  output logic [63:0]        reply_status_o,
  output logic [3:0]         reply_length_o,
  output logic signed [31:0] reply_stamp_o,
  output logic [7:0]         reply_kind_o,
  output logic [5:0]         occupied_count_o
);

  dst_pkg::ctrl_cmd_t cmd;
  dst_pkg::ctrl_sts_t sts;

  dst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dst_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .operation_i      (operation_i),
    .dev_id_i         (dev_id_i),
    .node_kind_i      (node_kind_i),
    .status_bytes_i   (status_bytes_i),
    .status_count_i   (status_count_i),
    .sync_stamp_i     (sync_stamp_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .outcome_o        (outcome_o),
    .slot_o           (slot_o),
    .reply_status_o   (reply_status_o),
    .reply_length_o   (reply_length_o),
    .reply_stamp_o    (reply_stamp_o),
    .reply_kind_o     (reply_kind_o),
    .occupied_count_o (occupied_count_o)
  );

endmodule

>>> hw/rtl/dst_ctrl.sv
// Controller of the device status table: sequences accept, table scan,
// drain of the last read and commit of the result.
// Depends on dst_pkg.
module dst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dst_pkg::ctrl_sts_t sts_i,
  output dst_pkg::ctrl_cmd_t cmd_o
);

  dst_pkg::state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      dst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = dst_pkg::ST_SCAN;
        end
      end
      dst_pkg::ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = dst_pkg::ST_DRAIN;
      end
      dst_pkg::ST_DRAIN: begin
        state_d = dst_pkg::ST_COMMIT;
      end
      dst_pkg::ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = dst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dst_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == dst_pkg::ST_IDLE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/dst_datapath.sv
// Datapath of the device status table: entry memory with per-entry valid
// bits, scan pointer, first-match and first-free search, entry update logic,
// occupancy counter, stamp register and result register.
// Depends on dst_pkg.
module dst_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dst_pkg::ctrl_cmd_t  cmd_i,
  output dst_pkg::ctrl_sts_t  sts_o,
  // config
  input  logic                cfg_we_i,
  input  logic signed [31:0]  cfg_wdata_i,
  // transaction in
  input  logic                operation_i,
  input  logic [63:0]         dev_id_i,
  input  logic [7:0]          node_kind_i,
  input  logic [63:0]         status_bytes_i,
  input  logic [3:0]          status_count_i,
  input  logic signed [31:0]  sync_stamp_i,
  // result out
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          outcome_o,
  output logic [4:0]          slot_o,
  output logic [63:0]         reply_status_o,
  output logic [3:0]          reply_length_o,
  output logic signed [31:0]  reply_stamp_o,
  output logic [7:0]          reply_kind_o,
  output logic [5:0]          occupied_count_o
);

  localparam int N = dst_pkg::TABLE_ENTRIES;
  localparam int IW = dst_pkg::IDX_W;

  // Captured transaction
  logic        op_q;
  logic [63:0] id_q;
  logic [7:0]  kind_q;
  logic [63:0] data_q;
  logic [3:0]  count_q;
  logic [31:0] stamp_q;

  // Table storage
  dst_pkg::entry_t mem [N];
  logic [N-1:0]    valid_q;
  logic [31:0]     new_stamp_q;
  logic [dst_pkg::OCC_W-1:0] occ_q;

  // Scan pipeline
  logic [IW-1:0]   cnt_q;
  logic            rd_vld_q;
  logic [IW-1:0]   rd_idx_q;
  dst_pkg::entry_t rd_raw_q;
  logic            rd_bit_q;
  dst_pkg::entry_t rd_entry;
  logic            rd_empty;

  // Search results
  logic            match_found_q;
  logic [IW-1:0]   match_idx_q;
  dst_pkg::entry_t match_q;
  logic            free_found_q;
  logic [IW-1:0]   free_idx_q;

  // Commit logic
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  dst_pkg::entry_t wr_entry;
  logic            occ_inc;
  dst_pkg::outcome_e outcome_d;
  logic [IW-1:0]   slot_idx_d;
  logic            reply_d;
  logic [3:0]      upd_n;
  logic [63:0]     upd_mask;
  logic [63:0]     upd_payload;
  logic            stamp_le;

  // Result register
  logic            out_valid_q;
  dst_pkg::outcome_e outcome_q;
  logic [4:0]      slot_q;
  logic [63:0]     reply_status_q;
  logic [3:0]      reply_length_q;
  logic [31:0]     reply_stamp_q;
  logic [7:0]      reply_kind_q;
  logic [5:0]      occ_out_q;

  // Status to controller
  assign sts_o.scan_last = (cnt_q == IW'(N - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q    <= operation_i;
      id_q    <= dev_id_i;
      kind_q  <= node_kind_i;
      data_q  <= status_bytes_i;
      count_q <= dst_pkg::clamp_count(status_count_i);
      stamp_q <= sync_stamp_i;
    end
  end

  // Memory: one read port for the scan, one write port for commit
  always_ff @(posedge clk_i) begin
    rd_raw_q <= mem[cnt_q];
    rd_bit_q <= valid_q[cnt_q];
    rd_idx_q <= cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_idx] <= wr_entry;
  end

  // Unwritten entries read as the reset value
  assign rd_entry = rd_bit_q ? rd_raw_q : dst_pkg::ENTRY_RESET;
  assign rd_empty = (rd_entry.kind == 8'h0) || (rd_entry.length == 4'h0);

  // Scan pointer and search flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      rd_vld_q      <= 1'b0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.start) begin
        cnt_q         <= '0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else begin
        if (cmd_i.scan) cnt_q <= sts_o.scan_last ? '0 : cnt_q + 1'b1;
        if (rd_vld_q && !rd_empty && (rd_entry.ident == id_q) && !match_found_q) begin
          match_found_q <= 1'b1;
        end
        if (rd_vld_q && rd_empty && !free_found_q) free_found_q <= 1'b1;
      end
    end
  end

  // Captured first match and first free slot
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && !rd_empty && (rd_entry.ident == id_q) && !match_found_q) begin
      match_idx_q <= rd_idx_q;
      match_q     <= rd_entry;
    end
    if (rd_vld_q && rd_empty && !free_found_q) free_idx_q <= rd_idx_q;
  end

  // Partial overwrite of the leading stored bytes
  assign upd_n       = (count_q < match_q.length) ? count_q : match_q.length;
  assign upd_mask    = dst_pkg::byte_mask(upd_n);
  assign upd_payload = (match_q.payload & ~upd_mask) | (data_q & upd_mask);
  assign stamp_le    = $signed(match_q.version) <= $signed(stamp_q);

  // Decide outcome and write-back entry
  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = match_idx_q;
    wr_entry   = match_q;
    occ_inc    = 1'b0;
    outcome_d  = dst_pkg::OUT_FULL;
    slot_idx_d = '0;
    reply_d    = 1'b0;
    if (op_q == dst_pkg::OP_REPORT) begin
      if (match_found_q) begin
        wr_en            = 1'b1;
        wr_entry.payload = upd_payload;
        wr_entry.version = match_q.version + 32'd1;
        outcome_d        = dst_pkg::OUT_UPDATED;
        slot_idx_d       = match_idx_q;
      end else if (free_found_q) begin
        wr_en            = 1'b1;
        wr_idx           = free_idx_q;
        wr_entry.ident   = id_q;
        wr_entry.kind    = kind_q;
        wr_entry.length  = count_q;
        wr_entry.payload = data_q & dst_pkg::byte_mask(count_q);
        wr_entry.version = new_stamp_q;
        occ_inc          = (kind_q != 8'h0) && (count_q != 4'h0);
        outcome_d        = dst_pkg::OUT_CREATED;
        slot_idx_d       = free_idx_q;
      end else begin
        outcome_d = dst_pkg::OUT_FULL;
      end
    end else begin
      if (!match_found_q) begin
        outcome_d = dst_pkg::OUT_SYNC_UNKNOWN;
      end else if (stamp_le) begin
        wr_en            = 1'b1;
        wr_entry.payload = upd_payload;
        wr_entry.version = stamp_q;
        outcome_d        = dst_pkg::OUT_SYNC_APPLIED;
        slot_idx_d       = match_idx_q;
      end else begin
        outcome_d  = dst_pkg::OUT_LOCAL_NEWER;
        slot_idx_d = match_idx_q;
        reply_d    = 1'b1;
      end
    end
    wr_en = wr_en && cmd_i.commit;
  end

  // Valid bits, occupancy, stamp register, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      new_stamp_q <= dst_pkg::STAMP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) new_stamp_q <= cfg_wdata_i;
      if (wr_en) valid_q[wr_idx] <= 1'b1;
      if (cmd_i.commit && occ_inc) occ_q <= occ_q + 1'b1;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      outcome_q      <= outcome_d;
      slot_q         <= dst_pkg::SLOT_W'(slot_idx_d);
      reply_status_q <= reply_d ? match_q.payload : 64'h0;
      reply_length_q <= reply_d ? match_q.length : 4'h0;
      reply_stamp_q  <= reply_d ? match_q.version : 32'h0;
      reply_kind_q   <= reply_d ? match_q.kind : 8'h0;
      occ_out_q      <= dst_pkg::OCC_OUT_W'(occ_inc ? occ_q + 1'b1 : occ_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign outcome_o        = outcome_q;
  assign slot_o           = slot_q;
  assign reply_status_o   = reply_status_q;
  assign reply_length_o   = reply_length_q;
  assign reply_stamp_o    = reply_stamp_q;
  assign reply_kind_o     = reply_kind_q;
  assign occupied_count_o = occ_out_q;

endmodule

>>> hw/rtl/dst_checker.sv
// Port-level checks for the device status table, bound to the top level.
// Depends on dst_pkg and device_status_table.
module dst_port_props (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         outcome_o,
  input logic [4:0]         slot_o,
  input logic [63:0]        reply_status_o,
  input logic [3:0]         reply_length_o,
  input logic signed [31:0] reply_stamp_o,
  input logic [7:0]         reply_kind_o
);

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its outcome and slot
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(outcome_o) && $stable(slot_o))
    else $error("result changed while stalled");

  // One transaction at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted during a scan");

  // Reply fields are zero and slot is zero where the outcome says so
  a_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o != dst_pkg::OUT_LOCAL_NEWER) |->
      (reply_length_o == 4'h0) && (reply_kind_o == 8'h0) &&
      (reply_stamp_o == 32'sh0) && (reply_status_o == 64'h0) &&
      ((outcome_o != dst_pkg::OUT_FULL && outcome_o != dst_pkg::OUT_SYNC_UNKNOWN) ||
       (slot_o == 5'h0)))
    else $error("reply or slot fields not cleared");

endmodule

bind device_status_table dst_port_props u_dst_port_props (.*);
